[src/wma_pkg.sv]
`default_nettype none

package wma_pkg;

  // Fixed field widths of the register file and result.
  localparam int unsigned TAP_W       = 3;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned NUM_WEIGHTS = 7;

  localparam int unsigned MAX_TAPS_DEF    = 7;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0  = 3'd1;

  localparam logic [TAP_W-1:0] TAP_COUNT_RST = 3'd4;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RST [NUM_WEIGHTS] = '{
    16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } wma_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_sample;
    logic mac_mul;
    logic mac_acc;
    logic div_init;
    logic div_step;
    logic out_load;
  } wma_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_tap;
    logic div_last;
    logic out_free;
  } wma_status_t;

endpackage

`default_nettype wire

[src/wma_intf.sv]
`default_nettype none

interface wma_sample_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wma_result_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          saturated;
  logic                          zero_weight_sum;
  logic [2:0]                    filled_taps;

  modport source (output valid, output average, output saturated,
                  output zero_weight_sum, output filled_taps, input ready);
  modport sink   (input valid, input average, input saturated,
                  input zero_weight_sum, input filled_taps, output ready);
endinterface

interface wma_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/wma_ctrl.sv]
`default_nettype none

module wma_ctrl
  import wma_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              smp_valid_i,
  output logic             smp_ready_o,
  input  wire wma_status_t status_i,
  output wma_cmd_t         cmd_o
);

  wma_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    smp_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        smp_ready_o = 1'b1;
        if (smp_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d           = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mac_mul = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.mac_acc = 1'b1;
        state_d       = status_i.last_tap ? ST_DIV_INIT : ST_MUL;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/wma_datapath.sv]
`default_nettype none

module wma_datapath
  import wma_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  wma_cmd_t                     cmd_i,
  output wma_status_t                        status_o,
  input  wire  signed [SAMPLE_BITS-1:0]      sample_i,
  input  wire                                cfg_we_i,
  input  wire         [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire         [CFG_DATA_W-1:0]       cfg_data_i,
  output logic                               res_valid_o,
  input  wire                                res_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      res_average_o,
  output logic                               res_saturated_o,
  output logic                               res_zero_o,
  output logic        [TAP_W-1:0]            res_filled_o
);

  localparam int unsigned SLOT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int unsigned PROD_W = SAMPLE_BITS + WEIGHT_W;
  localparam int unsigned ACC_W  = PROD_W + CNT_W;
  localparam int unsigned WSUM_W = WEIGHT_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(ACC_W);

  localparam logic [ACC_W-1:0] POS_LIM = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [ACC_W-1:0] NEG_LIM = ACC_W'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = SAMPLE_BITS'(POS_LIM);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = SAMPLE_BITS'(NEG_LIM);

  // configuration
  logic        [TAP_W-1:0]    tap_cnt_q;
  logic signed [WEIGHT_W-1:0] weight_q [NUM_WEIGHTS];

  // window
  logic signed [SAMPLE_BITS-1:0] ring_q [MAX_TAPS];
  logic [SLOT_W-1:0] wr_slot_q, rd_slot_q;
  logic [TAP_W-1:0]  fill_q, tap_idx_q;

  // accumulate and divide
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [WSUM_W-1:0] wsum_q;
  logic [ACC_W-1:0]         quo_q;
  logic [WSUM_W-1:0]        rem_q, dvs_q;
  logic [STEP_W-1:0]        step_q;
  logic                     neg_q, zero_q;

  // result register
  logic                          res_valid_q;
  logic signed [SAMPLE_BITS-1:0] res_avg_q;
  logic                          res_sat_q, res_zero_q;
  logic [TAP_W-1:0]              res_fill_q;

  logic [TAP_W-1:0]   taps_n, fill_eff;
  logic [SLOT_W-1:0]  wslot, wslot_next, rd_slot_next;
  logic [WSUM_W:0]    trial;
  logic               trial_ge;
  logic signed [SAMPLE_BITS-1:0] avg_d;
  logic               sat_d;

  always_comb begin
    if (tap_cnt_q == '0) begin
      taps_n = TAP_W'(1);
    end else if (tap_cnt_q > TAP_W'(MAX_TAPS)) begin
      taps_n = TAP_W'(MAX_TAPS);
    end else begin
      taps_n = tap_cnt_q;
    end
    wslot      = (TAP_W'(wr_slot_q) >= taps_n) ? '0 : wr_slot_q;
    wslot_next = ((TAP_W'(wslot) + TAP_W'(1)) >= taps_n) ? '0 : wslot + SLOT_W'(1);
    fill_eff   = (fill_q > taps_n) ? taps_n : fill_q;
    rd_slot_next = (rd_slot_q == '0) ? SLOT_W'(taps_n - TAP_W'(1)) : rd_slot_q - SLOT_W'(1);

    trial    = {rem_q, quo_q[ACC_W-1]};
    trial_ge = trial >= {1'b0, dvs_q};

    sat_d = 1'b0;
    if (zero_q) begin
      avg_d = '0;
    end else if (!neg_q && quo_q > POS_LIM) begin
      avg_d = SMP_MAX;
      sat_d = 1'b1;
    end else if (neg_q && quo_q > NEG_LIM) begin
      avg_d = SMP_MIN;
      sat_d = 1'b1;
    end else if (neg_q) begin
      avg_d = -$signed(quo_q[SAMPLE_BITS-1:0]);
    end else begin
      avg_d = $signed(quo_q[SAMPLE_BITS-1:0]);
    end
  end

  assign status_o.last_tap = (tap_idx_q + TAP_W'(1)) == fill_q;
  assign status_o.div_last = step_q == STEP_W'(ACC_W - 1);
  assign status_o.out_free = !res_valid_q || res_ready_i;

  // control part of the datapath: register file, window pointers, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_cnt_q <= TAP_COUNT_RST;
      for (int k = 0; k < NUM_WEIGHTS; k++) begin
        weight_q[k] <= WEIGHT_RST[k];
      end
      wr_slot_q   <= '0;
      fill_q      <= '0;
      rd_slot_q   <= '0;
      tap_idx_q   <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_sample) begin
        wr_slot_q <= wslot_next;
        fill_q    <= (fill_eff < taps_n) ? fill_eff + TAP_W'(1) : fill_eff;
        rd_slot_q <= wslot;
        tap_idx_q <= '0;
      end
      if (cmd_i.mac_acc) begin
        tap_idx_q <= tap_idx_q + TAP_W'(1);
        rd_slot_q <= rd_slot_next;
      end
      if (cmd_i.div_init) begin
        step_q <= '0;
      end
      if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      // writing the tap count restarts the window
      if (cfg_we_i) begin
        if (cfg_index_i == REG_TAP_COUNT) begin
          tap_cnt_q <= cfg_data_i[TAP_W-1:0];
          wr_slot_q <= '0;
          fill_q    <= '0;
        end else begin
          weight_q[cfg_index_i - REG_WEIGHT_0] <= $signed(cfg_data_i[WEIGHT_W-1:0]);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      ring_q[wslot] <= sample_i;
      acc_q         <= '0;
      wsum_q        <= '0;
    end
    if (cmd_i.mac_mul) begin
      prod_q <= ring_q[rd_slot_q] * weight_q[tap_idx_q];
    end
    if (cmd_i.mac_acc) begin
      acc_q  <= acc_q + ACC_W'(prod_q);
      wsum_q <= wsum_q + WSUM_W'(weight_q[tap_idx_q]);
    end
    if (cmd_i.div_init) begin
      neg_q  <= acc_q[ACC_W-1] ^ wsum_q[WSUM_W-1];
      zero_q <= wsum_q == '0;
      quo_q  <= acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
      dvs_q  <= wsum_q[WSUM_W-1] ? $unsigned(-wsum_q) : $unsigned(wsum_q);
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? WSUM_W'(trial - {1'b0, dvs_q}) : trial[WSUM_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], trial_ge};
    end
    if (cmd_i.out_load) begin
      res_avg_q  <= avg_d;
      res_sat_q  <= sat_d;
      res_zero_q <= zero_q;
      res_fill_q <= fill_q;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign res_average_o   = res_avg_q;
  assign res_saturated_o = res_sat_q;
  assign res_zero_o      = res_zero_q;
  assign res_filled_o    = res_fill_q;

endmodule

`default_nettype wire

[src/weighted_moving_average_filter.sv]
// Channel   Dir  Handshake     Payload
// smp_i     in   valid/ready   sample (signed, SAMPLE_BITS)
// res_o     out  valid/ready   average, saturated, zero_weight_sum, filled_taps
// cfg_i     in   valid/ready   index (3 bits), data (16 bits); ready is always high
//
// Each sample passes through its input transfer, a multiply and then an accumulate
// for every tap in the window, a divide set-up, one restoring divide step per
// quotient bit and a final load of the result; the pace is set by the serial
// divider and the shared multiplier, and the next sample waits until this is done.
// A finished result waits in the output register while the next sample is
// transferred in; a stalled output holds the block only at the end of the
// following sample. Reset restores the register defaults and empties the window.
`default_nettype none

module weighted_moving_average_filter
  import wma_pkg::*;
#(
  parameter int unsigned MAX_TAPS    = MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  wma_sample_if.sink   smp_i,
  wma_result_if.source res_o,
  wma_cfg_if.sink      cfg_i
);

  wma_cmd_t    cmd;
  wma_status_t status;

  // configuration writes are taken in any cycle
  assign cfg_i.ready = 1'b1;

  // sequencer: one sample at a time through multiply, accumulate and divide
  wma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp_i.valid),
    .smp_ready_o (smp_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // window, register file, multiply-accumulate, divider and output register
  wma_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_i        (smp_i.sample),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .res_average_o   (res_o.average),
    .res_saturated_o (res_o.saturated),
    .res_zero_o      (res_o.zero_weight_sum),
    .res_filled_o    (res_o.filled_taps)
  );

endmodule

`default_nettype wire
